// ===== hw/rtl/ccc_pkg.sv =====
`default_nettype none
package ccc_pkg;

   localparam int DefFractionBits = 16;
   localparam int SqStages = 16;   // two root bits per stage, 32 bits
   localparam int DvStages = 8;    // two quotient bits per stage, 16 bits
   localparam logic [15:0] NormOne = 16'd16384;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
   } sq_acc_type;

   typedef struct packed {
      logic        hit;
      logic        neg_x;
      logic        neg_y;
      logic [30:0] mag_x;
      logic [30:0] mag_y;
      logic [30:0] rsum;
   } sq_side_type;

   typedef struct packed {
      logic        hit;
      logic        neg_x;
      logic        neg_y;
      logic        small_dist;
      logic [30:0] depth;
   } dv_side_type;

   // one digit of the restoring square root
   function automatic sq_acc_type sq_step(sq_acc_type a, logic [1:0] pair);
      logic [35:0] r;
      logic [35:0] t;
      sq_acc_type  o;
      r = {a.rem[33:0], pair};
      t = {2'b00, a.root, 2'b01};
      if (r >= t) begin
         o.rem  = r - t;
         o.root = {a.root[30:0], 1'b1};
      end else begin
         o.rem  = r;
         o.root = {a.root[30:0], 1'b0};
      end
      return o;
   endfunction

   // one quotient bit: returns {bit, new remainder}
   function automatic logic [48:0] div_step(logic [47:0] rem, logic [47:0] dsh);
      logic [48:0] o;
      if (rem >= dsh) begin
         o = {1'b1, rem - dsh};
      end else begin
         o = {1'b0, rem};
      end
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ccc_sqrt.sv =====
`default_nettype none
module ccc_sqrt (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  wire                      in_vld,
   input  wire [63:0]               in_rad,
   input  wire ccc_pkg::sq_side_type in_side,
   output logic                     out_vld,
   output logic [31:0]              out_root,
   output ccc_pkg::sq_side_type     out_side
);
   import ccc_pkg::*;

   logic        vld_ff  [SqStages];
   sq_acc_type  acc_ff  [SqStages];
   logic [63:0] bits_ff [SqStages];
   sq_side_type side_ff [SqStages];

   for (genvar g = 0; g < SqStages; g++) begin : g_st
      logic        vld_in;
      sq_acc_type  acc_in;
      sq_acc_type  acc_mid;
      sq_acc_type  acc_out;
      logic [63:0] bits_in;
      sq_side_type side_in;

      if (g == 0) begin : g_first
         assign vld_in  = in_vld;
         assign acc_in  = '0;
         assign bits_in = in_rad;
         assign side_in = in_side;
      end else begin : g_next
         assign vld_in  = vld_ff[g-1];
         assign acc_in  = acc_ff[g-1];
         assign bits_in = bits_ff[g-1];
         assign side_in = side_ff[g-1];
      end

      always_comb begin
         acc_mid = sq_step(acc_in, bits_in[63:62]);
         acc_out = sq_step(acc_mid, bits_in[61:60]);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            acc_ff[g]  <= acc_out;
            bits_ff[g] <= {bits_in[59:0], 4'b0000};
            side_ff[g] <= side_in;
         end
      end
   end

   assign out_vld  = vld_ff[SqStages-1];
   assign out_root = acc_ff[SqStages-1].root;
   assign out_side = side_ff[SqStages-1];

endmodule
`default_nettype wire

// ===== hw/rtl/ccc_div.sv =====
`default_nettype none
module ccc_div (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      en,
   input  wire                      in_vld,
   input  wire [47:0]               in_num_x,
   input  wire [47:0]               in_num_y,
   input  wire [31:0]               in_den,
   input  wire ccc_pkg::dv_side_type in_side,
   output logic                     out_vld,
   output logic [15:0]              out_q_x,
   output logic [15:0]              out_q_y,
   output ccc_pkg::dv_side_type     out_side
);
   import ccc_pkg::*;

   logic        vld_ff  [DvStages];
   logic [47:0] rx_ff   [DvStages];
   logic [47:0] ry_ff   [DvStages];
   logic [15:0] qx_ff   [DvStages];
   logic [15:0] qy_ff   [DvStages];
   logic [31:0] den_ff  [DvStages];
   dv_side_type side_ff [DvStages];

   for (genvar g = 0; g < DvStages; g++) begin : g_st
      localparam int KHi = 15 - 2 * g;
      localparam int KLo = 14 - 2 * g;
      logic        vld_in;
      logic [47:0] rx_in;
      logic [47:0] ry_in;
      logic [15:0] qx_in;
      logic [15:0] qy_in;
      logic [31:0] den_in;
      dv_side_type side_in;
      logic [48:0] sx_hi, sx_lo, sy_hi, sy_lo;

      if (g == 0) begin : g_first
         assign vld_in  = in_vld;
         assign rx_in   = in_num_x;
         assign ry_in   = in_num_y;
         assign qx_in   = '0;
         assign qy_in   = '0;
         assign den_in  = in_den;
         assign side_in = in_side;
      end else begin : g_next
         assign vld_in  = vld_ff[g-1];
         assign rx_in   = rx_ff[g-1];
         assign ry_in   = ry_ff[g-1];
         assign qx_in   = qx_ff[g-1];
         assign qy_in   = qy_ff[g-1];
         assign den_in  = den_ff[g-1];
         assign side_in = side_ff[g-1];
      end

      always_comb begin
         sx_hi = div_step(rx_in, 48'(den_in) << KHi);
         sx_lo = div_step(sx_hi[47:0], 48'(den_in) << KLo);
         sy_hi = div_step(ry_in, 48'(den_in) << KHi);
         sy_lo = div_step(sy_hi[47:0], 48'(den_in) << KLo);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g] <= 1'b0;
         end else if (en) begin
            vld_ff[g] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rx_ff[g]   <= sx_lo[47:0];
            ry_ff[g]   <= sy_lo[47:0];
            qx_ff[g]   <= {qx_in[13:0], sx_hi[48], sx_lo[48]};
            qy_ff[g]   <= {qy_in[13:0], sy_hi[48], sy_lo[48]};
            den_ff[g]  <= den_in;
            side_ff[g] <= side_in;
         end
      end
   end

   assign out_vld  = vld_ff[DvStages-1];
   assign out_q_x  = qx_ff[DvStages-1];
   assign out_q_y  = qy_ff[DvStages-1];
   assign out_side = side_ff[DvStages-1];

endmodule
`default_nettype wire

// ===== hw/rtl/circle_circle_contact_unit.sv =====
`default_nettype none
// Circle-circle contact test, one pair word per cycle. Each request word
// carries two circles (position and collider offset in signed fixed point,
// radius unsigned); the response word says whether they overlap strictly
// and, on a hit, gives the unit normal from A to B in Q1.14 and the
// penetration depth in the input format. A miss reads all zeros. From
// accept to response valid, four stages form centres, offsets, squares and
// the hit compare, a 16-stage square root yields two root bits per stage,
// one stage builds the dividends, an 8-stage divider yields two normal bits
// per stage for both axes, and a response register closes the pipe. The
// pipe advances as a whole; it holds only while the response word is valid
// and stalled, so req_stall follows rsp_stall in that case alone.
// FRACTION_BITS sets only the coincident-centre epsilon.
module circle_circle_contact_unit #(
   parameter int FRACTION_BITS = ccc_pkg::DefFractionBits
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire signed [31:0]  req_pos_a_x,
   input  wire signed [31:0]  req_pos_a_y,
   input  wire signed [31:0]  req_off_a_x,
   input  wire signed [31:0]  req_off_a_y,
   input  wire [29:0]         req_radius_a,
   input  wire signed [31:0]  req_pos_b_x,
   input  wire signed [31:0]  req_pos_b_y,
   input  wire signed [31:0]  req_off_b_x,
   input  wire signed [31:0]  req_off_b_y,
   input  wire [29:0]         req_radius_b,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_hit,
   output logic signed [15:0] rsp_normal_x,
   output logic signed [15:0] rsp_normal_y,
   output logic [30:0]        rsp_depth
);
   import ccc_pkg::*;

   localparam logic [31:0] NormEps = 32'((64'd1 << FRACTION_BITS) / 64'd1000000);

   // whole pipe moves unless the response word is held
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage 1: centres and offset B minus A
   logic        s1_vld_ff;
   logic [33:0] s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic [30:0] s1_rsum_ff;
   logic [32:0] ax, ay, bx, by;

   always_comb begin
      ax = {req_pos_a_x[31], req_pos_a_x} + {req_off_a_x[31], req_off_a_x};
      ay = {req_pos_a_y[31], req_pos_a_y} + {req_off_a_y[31], req_off_a_y};
      bx = {req_pos_b_x[31], req_pos_b_x} + {req_off_b_x[31], req_off_b_x};
      by = {req_pos_b_y[31], req_pos_b_y} + {req_off_b_y[31], req_off_b_y};
      s1_dx_in = {bx[32], bx} - {ax[32], ax};
      s1_dy_in = {by[32], by} - {ay[32], ay};
   end

   // stage 2: magnitudes and far-apart flag
   logic        s2_vld_ff, s2_far_ff, s2_nx_ff, s2_ny_ff;
   logic [30:0] s2_mx_ff, s2_my_ff, s2_rsum_ff;
   logic [33:0] mx_in, my_in;

   always_comb begin
      mx_in = s1_dx_ff[33] ? (34'd0 - s1_dx_ff) : s1_dx_ff;
      my_in = s1_dy_ff[33] ? (34'd0 - s1_dy_ff) : s1_dy_ff;
   end

   // stage 3: squares
   logic        s3_vld_ff, s3_far_ff, s3_nx_ff, s3_ny_ff;
   logic [30:0] s3_mx_ff, s3_my_ff, s3_rsum_ff;
   logic [61:0] s3_sqx_ff, s3_sqy_ff, s3_rsq_ff;

   // stage 4: squared distance and hit compare
   logic        s4_vld_ff;
   logic [63:0] s4_rad_ff;
   sq_side_type s4_side_ff, s4_side_in;
   logic [62:0] dsq;
   logic        hit_in;

   always_comb begin
      dsq    = {1'b0, s3_sqx_ff} + {1'b0, s3_sqy_ff};
      hit_in = !s3_far_ff && (dsq < {1'b0, s3_rsq_ff});
      s4_side_in.hit   = hit_in;
      s4_side_in.neg_x = s3_nx_ff;
      s4_side_in.neg_y = s3_ny_ff;
      s4_side_in.mag_x = s3_mx_ff;
      s4_side_in.mag_y = s3_my_ff;
      s4_side_in.rsum  = s3_rsum_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s1_rsum_ff <= {1'b0, req_radius_a} + {1'b0, req_radius_b};

         s2_far_ff  <= (|mx_in[33:31]) || (|my_in[33:31]);
         s2_nx_ff   <= s1_dx_ff[33];
         s2_ny_ff   <= s1_dy_ff[33];
         s2_mx_ff   <= mx_in[30:0];
         s2_my_ff   <= my_in[30:0];
         s2_rsum_ff <= s1_rsum_ff;

         s3_far_ff  <= s2_far_ff;
         s3_nx_ff   <= s2_nx_ff;
         s3_ny_ff   <= s2_ny_ff;
         s3_mx_ff   <= s2_mx_ff;
         s3_my_ff   <= s2_my_ff;
         s3_rsum_ff <= s2_rsum_ff;
         s3_sqx_ff  <= s2_mx_ff * s2_mx_ff;
         s3_sqy_ff  <= s2_my_ff * s2_my_ff;
         s3_rsq_ff  <= s2_rsum_ff * s2_rsum_ff;

         // feed zero on a miss, the root is not used then
         s4_rad_ff  <= hit_in ? {2'b00, dsq[61:0]} : 64'd0;
         s4_side_ff <= s4_side_in;
      end
   end

   // square root pipeline
   logic        sq_vld;
   logic [31:0] sq_root;
   sq_side_type sq_side;

   ccc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s4_vld_ff),
      .in_rad   (s4_rad_ff),
      .in_side  (s4_side_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // stage 5: dividends, divisor, depth
   logic        s5_vld_ff;
   logic [47:0] s5_nx_ff, s5_ny_ff;
   logic [31:0] s5_den_ff;
   dv_side_type s5_side_ff, s5_side_in;
   logic [30:0] root_dist;
   logic        small_in;

   always_comb begin
      root_dist = sq_root[30:0];
      small_in  = {1'b0, root_dist} <= NormEps;
      s5_side_in.hit        = sq_side.hit;
      s5_side_in.neg_x      = sq_side.neg_x;
      s5_side_in.neg_y      = sq_side.neg_y;
      s5_side_in.small_dist = small_in;
      s5_side_in.depth      = sq_side.rsum - root_dist;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (en) begin
         s5_vld_ff <= sq_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_nx_ff   <= {2'b00, sq_side.mag_x, 15'd0} + {17'd0, root_dist};
         s5_ny_ff   <= {2'b00, sq_side.mag_y, 15'd0} + {17'd0, root_dist};
         // keep the divisor nonzero; the quotient is dropped when small
         s5_den_ff  <= (root_dist == 31'd0) ? 32'd1 : {root_dist, 1'b0};
         s5_side_ff <= s5_side_in;
      end
   end

   // normal divider pipeline
   logic        dv_vld;
   logic [15:0] dv_qx, dv_qy;
   dv_side_type dv_side;

   ccc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (s5_vld_ff),
      .in_num_x (s5_nx_ff),
      .in_num_y (s5_ny_ff),
      .in_den   (s5_den_ff),
      .in_side  (s5_side_ff),
      .out_vld  (dv_vld),
      .out_q_x  (dv_qx),
      .out_q_y  (dv_qy),
      .out_side (dv_side)
   );

   // response register: clamp, sign, zero on a miss
   logic        rsp_valid_ff, rsp_hit_ff;
   logic [15:0] rsp_nx_ff, rsp_ny_ff, rsp_nx_in, rsp_ny_in;
   logic [30:0] rsp_depth_ff, rsp_depth_in;
   logic [15:0] cx, cy;

   always_comb begin
      cx = (dv_qx > NormOne) ? NormOne : dv_qx;
      cy = (dv_qy > NormOne) ? NormOne : dv_qy;
      priority if (!dv_side.hit) begin
         rsp_nx_in    = '0;
         rsp_ny_in    = '0;
         rsp_depth_in = '0;
      end else if (dv_side.small_dist) begin
         rsp_nx_in    = NormOne;
         rsp_ny_in    = '0;
         rsp_depth_in = dv_side.depth;
      end else begin
         rsp_nx_in    = dv_side.neg_x ? (16'd0 - cx) : cx;
         rsp_ny_in    = dv_side.neg_y ? (16'd0 - cy) : cy;
         rsp_depth_in = dv_side.depth;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_hit_ff   <= dv_side.hit;
         rsp_nx_ff    <= rsp_nx_in;
         rsp_ny_ff    <= rsp_ny_in;
         rsp_depth_ff <= rsp_depth_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_normal_x = rsp_nx_ff;
   assign rsp_normal_y = rsp_ny_ff;
   assign rsp_depth    = rsp_depth_ff;

   // a miss carries no normal and no depth
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_normal_x == 16'sd0 && rsp_normal_y == 16'sd0
                                && rsp_depth == 31'd0)
      else $error("miss response carries nonzero payload");

   // a hit always penetrates
   a_hit_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_depth != 31'd0)
      else $error("hit with zero depth");

   // normal stays within the unit range
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_normal_x >= -16'sd16384 && rsp_normal_x <= 16'sd16384
                               && rsp_normal_y >= -16'sd16384 && rsp_normal_y <= 16'sd16384)
      else $error("normal out of range");

   // input holds only behind a held response word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output back-pressure");

endmodule
`default_nettype wire
